[rtl/core/glt_pkg.sv]
// ============================================================================
// glt_pkg
// Shared types and constants of the generational lease table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package glt_pkg;

    typedef logic [1:0] t_func;

    localparam t_func FN_PUBLISH         = 2'd0;
    localparam t_func FN_COPY            = 2'd1;
    localparam t_func FN_RELEASE         = 2'd2;
    localparam t_func FN_RELEASE_SESSION = 2'd3;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BAD_SESSION = 3'd1;
    localparam t_status ST_TOO_LARGE   = 3'd2;
    localparam t_status ST_BUDGET      = 3'd3;
    localparam t_status ST_FULL        = 3'd4;
    localparam t_status ST_STALE       = 3'd5;
    localparam t_status ST_MISMATCH    = 3'd6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTE_BUDGET = 1'd1;

    localparam logic [15:0] MAX_LEASE_BYTES_RESET   = 16'd4096;
    localparam logic [23:0] TOTAL_BYTE_BUDGET_RESET = 24'd65536;

    typedef struct packed {
        logic        active;
        logic [15:0] generation;
        logic [31:0] owner_app;
        logic [31:0] owner_generation;
        logic [31:0] owner_epoch;
        logic [15:0] length;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic  owner_match;
        logic  handle_match;
        t_slot freed;
    } t_slot_eval;

    function automatic t_slot slot_reset_value();
        t_slot s;
        s.active           = 1'b0;
        s.generation       = 16'd1;
        s.owner_app        = 32'd0;
        s.owner_generation = 32'd0;
        s.owner_epoch      = 32'd0;
        s.length           = 16'd0;
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/generational_lease_table.sv]
// ============================================================================
// generational_lease_table
// A rejected publish or a bad handle goes straight to the emit state; copy
// and release first read the addressed slot, publish scans for a free slot
// and release-session scans all slots. The result is then registered at the
// output once the output register is free. A new transaction is accepted the
// cycle after the previous result is handed to the output register; one slot
// is read from the table RAM per cycle. After reset a clearing pass writes
// every slot; input transactions wait, configuration writes do not.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module generational_lease_table import glt_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_func,
    input  wire logic [31:0]           i_session_app,
    input  wire logic [31:0]           i_session_generation,
    input  wire logic [31:0]           i_session_epoch,
    input  wire logic [15:0]           i_payload_length,
    input  wire logic [31:0]           i_lease_handle,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [2:0]                 o_status,
    output logic [31:0]                o_lease_handle_out,
    output logic [15:0]                o_stored_length,
    output logic [4:0]                 o_released_count,
    output logic [23:0]                o_bytes_in_use,
    output logic [4:0]                 o_leases_active,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(SLOT_COUNT - 1);
    localparam logic [16:0]   SLOT_LIMIT = 17'(SLOT_COUNT);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PUB   = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_RELS  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0]   r_max_lease;
    logic [23:0]   r_budget;
    logic [23:0]   r_used, n_used;
    logic [CW-1:0] r_active, n_active;
    logic [4:0]    r_rel_cnt, n_rel_cnt;

    t_func         r_func;
    logic [31:0]   r_app, r_sgen, r_sep;
    logic [15:0]   r_len;
    logic [31:0]   r_handle;

    t_status       r_res_status, n_res_status;
    logic [31:0]   r_res_handle, n_res_handle;
    logic [15:0]   r_res_stored, n_res_stored;
    logic [4:0]    r_res_released, n_res_released;

    logic          r_out_valid;
    t_status       r_out_status;
    logic [31:0]   r_out_handle;
    logic [15:0]   r_out_stored;
    logic [4:0]    r_out_released;
    logic [23:0]   r_out_bytes;
    logic [4:0]    r_out_active;

    logic          in_accept;
    logic          out_free;
    logic [15:0]   handle_low;
    logic [15:0]   handle_idx16;
    logic          handle_ok;
    logic [23:0]   room;
    logic [23:0]   len_in24;
    logic [23:0]   slot_len24;
    logic [23:0]   used_after_free;
    logic [CW-1:0] active_dec;
    logic [IW-1:0] next_idx;
    logic [16:0]   idx_plus;
    logic [CW+4:0] active_ext;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_slot         wr_data;
    logic [IW-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_bits;
    t_slot         rd_slot;
    t_slot_eval    slot_eval;

    glt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_slot = t_slot'(rd_bits);

    glt_slot_eval u_eval (
        .i_slot       (rd_slot),
        .i_app        (r_app),
        .i_generation (r_sgen),
        .i_epoch      (r_sep),
        .i_handle_gen (r_handle[31:16]),
        .o_eval       (slot_eval)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign handle_low      = i_lease_handle[15:0];
    assign handle_idx16    = handle_low - 16'd1;
    assign handle_ok       = (handle_low != 16'd0) && ({1'b0, handle_low} <= SLOT_LIMIT);
    assign room            = r_budget - ((r_used < r_budget) ? r_used : r_budget);
    assign len_in24        = {8'd0, i_payload_length};
    assign slot_len24      = {8'd0, rd_slot.length};
    assign used_after_free = r_used - ((slot_len24 < r_used) ? slot_len24 : r_used);
    assign active_dec      = (r_active != '0) ? (r_active - CW'(1)) : r_active;
    assign next_idx        = r_idx + IW'(1);
    assign idx_plus        = 17'(r_idx) + 17'd1;
    assign active_ext      = {5'd0, r_active};

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_used         = r_used;
        n_active       = r_active;
        n_rel_cnt      = r_rel_cnt;
        n_res_status   = r_res_status;
        n_res_handle   = r_res_handle;
        n_res_stored   = r_res_stored;
        n_res_released = r_res_released;
        rd_addr        = r_idx;
        wr_en          = 1'b0;
        wr_addr        = r_idx;
        wr_data        = slot_reset_value();

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = next_idx;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_res_status   = ST_OK;
                    n_res_handle   = 32'd0;
                    n_res_stored   = 16'd0;
                    n_res_released = 5'd0;
                    n_rel_cnt      = 5'd0;
                    n_idx          = '0;
                    rd_addr        = '0;
                    unique case (i_func)
                        FN_PUBLISH: begin
                            priority if (i_session_app == 32'd0) begin
                                n_res_status = ST_BAD_SESSION;
                                n_state      = S_EMIT;
                            end else if (i_payload_length > r_max_lease) begin
                                n_res_status = ST_TOO_LARGE;
                                n_state      = S_EMIT;
                            end else if (len_in24 > room) begin
                                n_res_status = ST_BUDGET;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_PUB;
                            end
                        end
                        FN_COPY, FN_RELEASE: begin
                            if (!handle_ok) begin
                                n_res_status = ST_STALE;
                                n_state      = S_EMIT;
                            end else begin
                                n_idx   = handle_idx16[IW-1:0];
                                rd_addr = handle_idx16[IW-1:0];
                                n_state = S_LOOK;
                            end
                        end
                        FN_RELEASE_SESSION: begin
                            n_state = S_RELS;
                        end
                    endcase
                end
            end
            S_PUB: begin
                if (!rd_slot.active) begin
                    wr_en                    = 1'b1;
                    wr_data.active           = 1'b1;
                    wr_data.generation       = rd_slot.generation;
                    wr_data.owner_app        = r_app;
                    wr_data.owner_generation = r_sgen;
                    wr_data.owner_epoch      = r_sep;
                    wr_data.length           = r_len;
                    n_active                 = r_active + CW'(1);
                    n_used                   = r_used + {8'd0, r_len};
                    n_res_handle             = {rd_slot.generation, idx_plus[15:0]};
                    n_state                  = S_EMIT;
                end else if (r_idx == LAST_IDX) begin
                    n_res_status = ST_FULL;
                    n_state      = S_EMIT;
                end else begin
                    n_idx   = next_idx;
                    rd_addr = next_idx;
                end
            end
            S_LOOK: begin
                priority if (!slot_eval.handle_match) begin
                    n_res_status = ST_STALE;
                end else if (!slot_eval.owner_match) begin
                    n_res_status = ST_MISMATCH;
                end else if (r_func == FN_COPY) begin
                    n_res_stored = rd_slot.length;
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = slot_eval.freed;
                    n_used   = used_after_free;
                    n_active = active_dec;
                end
                n_state = S_EMIT;
            end
            S_RELS: begin
                if (rd_slot.active && slot_eval.owner_match) begin
                    wr_en     = 1'b1;
                    wr_data   = slot_eval.freed;
                    n_used    = used_after_free;
                    n_active  = active_dec;
                    n_rel_cnt = r_rel_cnt + 5'd1;
                end
                if (r_idx == LAST_IDX) begin
                    n_res_released = n_rel_cnt;
                    n_state        = S_EMIT;
                end else begin
                    n_idx   = next_idx;
                    rd_addr = next_idx;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_used      <= 24'd0;
            r_active    <= '0;
            r_rel_cnt   <= 5'd0;
            r_out_valid <= 1'b0;
            r_max_lease <= MAX_LEASE_BYTES_RESET;
            r_budget    <= TOTAL_BYTE_BUDGET_RESET;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_active  <= n_active;
            r_rel_cnt <= n_rel_cnt;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_LEASE_BYTES:   r_max_lease <= i_cfg_data[15:0];
                    CFG_TOTAL_BYTE_BUDGET: r_budget    <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func   <= i_func;
            r_app    <= i_session_app;
            r_sgen   <= i_session_generation;
            r_sep    <= i_session_epoch;
            r_len    <= i_payload_length;
            r_handle <= i_lease_handle;
        end
        r_res_status   <= n_res_status;
        r_res_handle   <= n_res_handle;
        r_res_stored   <= n_res_stored;
        r_res_released <= n_res_released;
        if (r_state == S_EMIT && out_free) begin
            r_out_status   <= r_res_status;
            r_out_handle   <= r_res_handle;
            r_out_stored   <= r_res_stored;
            r_out_released <= r_res_released;
            r_out_bytes    <= r_used;
            r_out_active   <= active_ext[4:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_lease_handle_out = r_out_handle;
    assign o_stored_length    = r_out_stored;
    assign o_released_count   = r_out_released;
    assign o_bytes_in_use     = r_out_bytes;
    assign o_leases_active    = r_out_active;

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CW'(SLOT_COUNT))
        else $error("active lease count exceeds the slot count");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR || r_state == S_PUB ||
                   r_state == S_LOOK || r_state == S_RELS))
        else $error("table written outside a table access state");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result presented without a completed transaction");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUB || r_state == S_RELS || r_state == S_CLEAR) |->
            r_idx <= LAST_IDX)
        else $error("slot index beyond the table");

endmodule

`default_nettype wire

[rtl/core/glt_ram.sv]
// ============================================================================
// glt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module glt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/glt_slot_eval.sv]
// ============================================================================
// glt_slot_eval
// Checks a slot read from the table against the current session and handle,
// and forms the slot contents after it is freed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module glt_slot_eval import glt_pkg::*; (
    input  wire t_slot         i_slot,
    input  wire logic [31:0]   i_app,
    input  wire logic [31:0]   i_generation,
    input  wire logic [31:0]   i_epoch,
    input  wire logic [15:0]   i_handle_gen,
    output t_slot_eval         o_eval
);

    logic [15:0] gen_inc;

    assign gen_inc = i_slot.generation + 16'd1;

    always_comb begin
        o_eval.owner_match  = (i_slot.owner_app == i_app) &&
                              (i_slot.owner_generation == i_generation) &&
                              (i_slot.owner_epoch == i_epoch);
        o_eval.handle_match = i_slot.active && (i_slot.generation == i_handle_gen);
        o_eval.freed.active           = 1'b0;
        o_eval.freed.generation       = (gen_inc == 16'd0) ? 16'd1 : gen_inc;
        o_eval.freed.owner_app        = 32'd0;
        o_eval.freed.owner_generation = 32'd0;
        o_eval.freed.owner_epoch      = 32'd0;
        o_eval.freed.length           = i_slot.length;
    end

endmodule

`default_nettype wire
